@@ sv/assert_macros.svh @@
// Assertion macros used by the TGA stream decoder core.
// Each macro is empty when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising aclk edge outside reset.
`define TGAD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next one.
`define TGAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TGAD_ASSERT(lbl, prop, msg)
`define TGAD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/tgad_pkg.sv @@
// Types and constants for the TGA true-color stream decoder.
// Used by every module of the block; depends on nothing else.
package tgad_pkg;

    localparam int DATA_W    = 8;
    localparam int DIM_W     = 16;
    localparam int INDEX_W   = 32;
    localparam int LENGTH_W  = 32;
    localparam int M_TDATA_W = 104;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_SHORT_HEADER = 3'd0,
        ERR_COLOR_MAP    = 3'd1,
        ERR_NOT_RGB      = 3'd2,
        ERR_BAD_DEPTH    = 3'd3,
        ERR_SHORT_RASTER = 3'd4
    } err_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_SKIP   = 4'b0100,
        PH_RASTER = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              first_byte;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        err_t               error_code;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic               origin_top;
        logic [INDEX_W-1:0] pixel_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               last;
    } result_t;

endpackage

@@ sv/tgad_in_stage.sv @@
// Input register of the TGA decoder: holds one accepted byte for the parser.
// Depends on tgad_pkg.
module tgad_in_stage
    import tgad_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     pop,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    // The slot frees up in the same cycle that the parser consumes it.
    assign s_ready    = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ sv/tgad_core.sv @@
// Header parser, size checks and BGR(A) to RGBA conversion of the TGA decoder.
// Depends on tgad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tgad_core
    import tgad_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  in_item_t            item,
    input  logic [LENGTH_W-1:0] file_length,
    output logic                res_valid,
    output result_t             res
);

    localparam logic [8:0] POS_ID_LEN   = 9'd0;
    localparam logic [8:0] POS_MAP_TYPE = 9'd1;
    localparam logic [8:0] POS_IMG_TYPE = 9'd2;
    localparam logic [8:0] POS_WIDTH_LO = 9'd12;
    localparam logic [8:0] POS_WIDTH_HI = 9'd13;
    localparam logic [8:0] POS_HGT_LO   = 9'd14;
    localparam logic [8:0] POS_HGT_HI   = 9'd15;
    localparam logic [8:0] POS_DEPTH    = 9'd16;
    localparam logic [8:0] POS_DESCR    = 9'd17;
    localparam logic [8:0] HEADER_LEN   = 9'd18;

    phase_t             phase_reg, phase_next;
    logic [8:0]         pos_reg, pos_next;
    logic [8:0]         base_reg, base_next;
    logic [7:0]         id_len_reg, id_len_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic               four_reg, four_next;
    logic               top_reg, top_next;
    logic [1:0]         cc_reg, cc_next;
    logic [23:0]        held_reg, held_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [INDEX_W-1:0] row_base_reg, row_base_next;
    logic [31:0]        left_reg, left_next;
    logic [31:0]        npix_reg, npix_next;
    logic [33:0]        raster_reg, raster_next;
    logic [31:0]        row_last_reg, row_last_next;

    phase_t     phase_eff;
    logic [8:0] pos_eff;
    logic [7:0] b;
    logic [33:0] total_bytes;
    logic [DIM_W-1:0] col_inc;
    logic [1:0] last_ch;

    assign b         = item.data_byte;
    assign phase_eff = item.first_byte ? PH_HEADER : phase_reg;
    assign pos_eff   = item.first_byte ? POS_ID_LEN : pos_reg;
    assign total_bytes = raster_reg + {25'd0, base_reg};
    assign col_inc   = col_reg + 16'd1;
    assign last_ch   = four_reg ? 2'd3 : 2'd2;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        base_next     = base_reg;
        id_len_next   = id_len_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        four_next     = four_reg;
        top_next      = top_reg;
        cc_next       = cc_reg;
        held_next     = held_reg;
        col_next      = col_reg;
        row_base_next = row_base_reg;
        left_next     = left_reg;
        npix_next     = npix_reg;
        raster_next   = raster_reg;
        row_last_next = row_last_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_SHORT_HEADER;

        case (phase_eff)
            PH_HEADER: begin
                phase_next = PH_HEADER;
                pos_next   = (pos_eff < POS_DESCR) ? pos_eff + 9'd1 : pos_eff;
                case (pos_eff)
                    POS_ID_LEN: begin
                        id_len_next = b;
                        base_next   = HEADER_LEN + {1'b0, b};
                        if (file_length < {23'd0, base_next}) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_SHORT_HEADER;
                            res.last       = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                    end
                    POS_MAP_TYPE: begin
                        if (b != 8'd0) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_COLOR_MAP;
                            res.last       = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                    end
                    POS_IMG_TYPE: begin
                        if (b != 8'd2) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_NOT_RGB;
                            res.last       = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                    end
                    POS_WIDTH_LO: width_next  = {width_reg[15:8], b};
                    POS_WIDTH_HI: width_next  = {b, width_reg[7:0]};
                    POS_HGT_LO:   height_next = {height_reg[15:8], b};
                    POS_HGT_HI: begin
                        height_next = {b, height_reg[7:0]};
                        // Pixel count is formed as the height's high byte arrives.
                        npix_next   = {16'd0, width_reg} * {16'd0, b, height_reg[7:0]};
                    end
                    POS_DEPTH: begin
                        four_next     = (b == 8'd32);
                        raster_next   = (b == 8'd32) ? {npix_reg, 2'b00}
                                      : {2'b00, npix_reg} + {1'b0, npix_reg, 1'b0};
                        row_last_next = (height_reg == '0) ? '0
                                      : npix_reg - {16'd0, width_reg};
                        if (b != 8'd24 && b != 8'd32) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_BAD_DEPTH;
                            res.width      = width_reg;
                            res.height     = height_reg;
                            res.last       = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                    end
                    POS_DESCR: begin
                        top_next  = b[5];
                        res_valid = 1'b1;
                        if (total_bytes > {2'b00, file_length}) begin
                            res.error_code = ERR_SHORT_RASTER;
                            res.width      = width_reg;
                            res.height     = height_reg;
                            res.last       = 1'b1;
                            phase_next     = PH_IDLE;
                        end else begin
                            res.kind       = KIND_HEADER;
                            res.width      = width_reg;
                            res.height     = height_reg;
                            res.origin_top = b[5];
                            res.last       = (npix_reg == '0);
                            left_next      = npix_reg;
                            col_next       = '0;
                            cc_next        = '0;
                            held_next      = '0;
                            row_base_next  = b[5] ? '0 : row_last_reg;
                            pos_next       = HEADER_LEN;
                            if (npix_reg == '0) begin
                                phase_next = PH_IDLE;
                            end else if (id_len_reg != 8'd0) begin
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_RASTER;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            PH_SKIP: begin
                pos_next = pos_reg + 9'd1;
                if (pos_next >= base_reg) begin
                    phase_next = PH_RASTER;
                end
            end
            PH_RASTER: begin
                if (cc_reg < last_ch) begin
                    case (cc_reg)
                        2'd0:    held_next[7:0]   = b;
                        2'd1:    held_next[15:8]  = b;
                        default: held_next[23:16] = b;
                    endcase
                    cc_next = cc_reg + 2'd1;
                end else begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_PIXEL;
                    res.pixel_index = row_base_reg + {16'd0, col_reg};
                    res.blue        = held_reg[7:0];
                    res.green       = held_reg[15:8];
                    res.red         = four_reg ? held_reg[23:16] : b;
                    res.alpha       = four_reg ? b : 8'hFF;
                    cc_next         = '0;
                    held_next       = '0;
                    if (col_inc >= width_reg) begin
                        col_next      = '0;
                        row_base_next = top_reg ? row_base_reg + {16'd0, width_reg}
                                      : row_base_reg - {16'd0, width_reg};
                    end else begin
                        col_next = col_inc;
                    end
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1) begin
                        res.last   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            base_reg     <= base_next;
            id_len_reg   <= id_len_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            four_reg     <= four_next;
            top_reg      <= top_next;
            cc_reg       <= cc_next;
            held_reg     <= held_next;
            col_reg      <= col_next;
            row_base_reg <= row_base_next;
            left_reg     <= left_next;
            npix_reg     <= npix_next;
            raster_reg   <= raster_next;
            row_last_reg <= row_last_next;
        end
    end

    `TGAD_ASSERT(a_pixels_pending,
        (phase_reg == PH_SKIP || phase_reg == PH_RASTER) |-> left_reg != 32'd0,
        "image phase with no pixels left")
    `TGAD_ASSERT(a_column_in_row,
        (phase_reg == PH_RASTER) |-> col_reg < width_reg,
        "column beyond image width")
    `TGAD_ASSERT(a_channel_count,
        (phase_reg == PH_RASTER && !four_reg) |-> cc_reg != 2'd3,
        "fourth channel held for 24-bit data")
    `TGAD_ASSERT(a_idle_silent,
        (step && phase_reg == PH_IDLE && !item.first_byte) |-> !res_valid,
        "result produced while idle")
    `TGAD_ASSERT_NEXT(a_last_to_idle,
        step && res_valid && res.last, phase_reg == PH_IDLE,
        "parser not idle after final result")

endmodule

@@ sv/tgad_out_stage.sv @@
// Output register of the TGA decoder: holds one result until the sink takes it.
// Depends on tgad_pkg.
module tgad_out_stage
    import tgad_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_res,
    output logic    can_take,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_take) begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && can_take) begin
            res_reg <= push_res;
        end
    end

endmodule

@@ sv/tga_truecolor_stream_decoder_top.sv @@
// Top level of the TGA true-color stream decoder: ports, file length register.
// Depends on tgad_pkg, tgad_in_stage, tgad_core and tgad_out_stage.
//
//  Port group  Dir  Moves
//  s_*         in   one file byte per transfer, s_tuser marks the first byte
//  m_*         out  header, pixel or error result, m_tlast on the file's last
//  cfg_*       in   file length in bytes
//
// One byte per cycle sustained while m_tready stays high; a result reaches m_* through
// the input register, the parser logic and the output register.
// The deepest logic is the 16 by 16 pixel count product at the height's high
// byte; the 34-bit raster size add and compare follows at the final header byte.
// Reset is synchronous and clears the handshake state and the parser phase.
// A stalled m_tready backs up to s_tready only once both registers are full.
module tga_truecolor_stream_decoder_top
    import tgad_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,      // [7:0] data_byte
    input  logic [0:0]           s_tuser,      // [0] first_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] error_code, [18:3] width, [34:19] height, [35] origin_top,
    // [67:36] pixel_index, [75:68] red, [83:76] green, [91:84] blue,
    // [99:92] alpha, [103:100] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser,      // [1:0] kind
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [LENGTH_W-1:0]  cfg_wr_data
);

    logic [LENGTH_W-1:0] file_length_reg;
    in_item_t            s_item;
    in_item_t            item;
    logic                item_valid;
    logic                can_take;
    logic                step;
    logic                res_valid;
    result_t             res;
    result_t             m_res;

    assign s_item.data_byte  = s_tdata;
    assign s_item.first_byte = s_tuser[0];
    assign step              = item_valid && can_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
        end else if (cfg_wr_en) begin
            file_length_reg <= cfg_wr_data;
        end
    end

    tgad_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .pop        (step),
        .item_valid (item_valid),
        .item       (item)
    );

    tgad_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .item        (item),
        .file_length (file_length_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    tgad_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (step && res_valid),
        .push_res (res),
        .can_take (can_take),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {4'd0, m_res.alpha, m_res.blue, m_res.green, m_res.red,
                      m_res.pixel_index, m_res.origin_top, m_res.height,
                      m_res.width, m_res.error_code};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule

@@ sim/tga_truecolor_stream_decoder_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for tga_truecolor_stream_decoder_top: streams TGA files byte by byte
// and checks every header, pixel and error result against a predictor kept in this file.
// Depends on tgad_pkg and the decoder RTL; needs no files or arguments.
module tga_truecolor_stream_decoder_top_test;
    import tgad_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [LENGTH_W-1:0]  cfg_wr_data = '0;

    tga_truecolor_stream_decoder_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    in_item_t    file_bytes_q[$];
    result_t     decoded_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          fail_count = 0;
    int unsigned quiet_cycles = 0;

    // Predictor state.
    logic [31:0] file_len = '0;
    phase_t      dec_phase = PH_IDLE;
    logic [8:0]  hdr_pos = '0;
    logic [7:0]  id_len = '0;
    logic [15:0] img_w = '0;
    logic [15:0] img_h = '0;
    logic        four_ch = 1'b0;
    logic        top_first = 1'b0;
    logic [1:0]  chan_cnt = '0;
    logic [23:0] held_bytes = '0;
    logic [15:0] col = '0;
    logic [31:0] row_base = '0;
    logic [31:0] pix_left = '0;

    bit          emit_now;
    result_t     predicted;
    in_item_t    next_byte;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic raise_error(input err_t code, input bit with_size, output result_t r);
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        if (with_size) begin
            r.width = img_w;
            r.height = img_h;
        end
        r.last = 1'b1;
        dec_phase = PH_IDLE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic first,
                               output bit emit, output result_t r);
        logic [8:0]      pos;
        longint unsigned npix;
        longint unsigned need;
        int              nch;
        emit = 1'b0;
        r = '0;
        if (first) begin
            dec_phase = PH_HEADER;
            hdr_pos = '0;
        end
        nch = four_ch ? 4 : 3;
        case (dec_phase)
            PH_HEADER: begin
                pos = hdr_pos;
                if (pos < 17) hdr_pos = pos + 9'd1;
                case (pos)
                    0: begin
                        id_len = b;
                        if (64'(file_len) < 64'd18 + 64'(b)) begin
                            raise_error(ERR_SHORT_HEADER, 1'b0, r);
                            emit = 1'b1;
                        end
                    end
                    1: if (b != 8'd0) begin
                        raise_error(ERR_COLOR_MAP, 1'b0, r);
                        emit = 1'b1;
                    end
                    2: if (b != 8'd2) begin
                        raise_error(ERR_NOT_RGB, 1'b0, r);
                        emit = 1'b1;
                    end
                    12: img_w[7:0] = b;
                    13: img_w[15:8] = b;
                    14: img_h[7:0] = b;
                    15: img_h[15:8] = b;
                    16: begin
                        if (b != 8'd24 && b != 8'd32) begin
                            raise_error(ERR_BAD_DEPTH, 1'b1, r);
                            emit = 1'b1;
                        end else begin
                            four_ch = (b == 8'd32);
                        end
                    end
                    17: begin
                        npix = 64'(img_w) * 64'(img_h);
                        top_first = b[5];
                        need = 64'd18 + 64'(id_len) + npix * (four_ch ? 64'd4 : 64'd3);
                        emit = 1'b1;
                        if (need > 64'(file_len)) begin
                            raise_error(ERR_SHORT_RASTER, 1'b1, r);
                        end else begin
                            r.kind = KIND_HEADER;
                            r.width = img_w;
                            r.height = img_h;
                            r.origin_top = top_first;
                            r.last = (npix == 0);
                            pix_left = 32'(npix);
                            col = '0;
                            chan_cnt = '0;
                            held_bytes = '0;
                            if (top_first || img_h == 16'd0)
                                row_base = '0;
                            else
                                row_base = 32'(img_h - 16'd1) * 32'(img_w);
                            hdr_pos = 9'd18;
                            if (npix == 0)
                                dec_phase = PH_IDLE;
                            else
                                dec_phase = (id_len != 0) ? PH_SKIP : PH_RASTER;
                        end
                    end
                    default: ;
                endcase
            end
            PH_SKIP: begin
                hdr_pos = hdr_pos + 9'd1;
                if (int'(hdr_pos) >= 18 + int'(id_len)) dec_phase = PH_RASTER;
            end
            PH_RASTER: begin
                if (int'(chan_cnt) + 1 < nch) begin
                    held_bytes[8*chan_cnt +: 8] = b;
                    chan_cnt = chan_cnt + 2'd1;
                end else begin
                    emit = 1'b1;
                    r.kind = KIND_PIXEL;
                    r.pixel_index = row_base + 32'(col);
                    r.blue = held_bytes[7:0];
                    r.green = held_bytes[15:8];
                    r.red = (nch == 3) ? b : held_bytes[23:16];
                    r.alpha = (nch == 3) ? 8'd255 : b;
                    chan_cnt = '0;
                    held_bytes = '0;
                    if (17'(col) + 17'd1 >= 17'(img_w)) begin
                        col = '0;
                        if (top_first)
                            row_base = row_base + 32'(img_w);
                        else
                            row_base = row_base - 32'(img_w);
                    end else begin
                        col = col + 16'd1;
                    end
                    pix_left = pix_left - 32'd1;
                    if (pix_left == 0) begin
                        r.last = 1'b1;
                        dec_phase = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Byte source: a new byte is offered only once the previous transfer is done.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser[0], emit_now, predicted);
                if (emit_now) decoded_q.push_back(predicted);
            end
            if (!s_tvalid || s_tready) begin
                if (file_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = file_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_byte.data_byte;
                    s_tuser <= next_byte.first_byte;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("result with nothing expected: kind %0d", m_tuser);
                    fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(m_tuser));
                    compare_field("error_code", 32'(want.error_code), 32'(m_tdata[2:0]));
                    compare_field("width", 32'(want.width), 32'(m_tdata[18:3]));
                    compare_field("height", 32'(want.height), 32'(m_tdata[34:19]));
                    compare_field("origin_top", 32'(want.origin_top), 32'(m_tdata[35]));
                    compare_field("pixel_index", want.pixel_index, m_tdata[67:36]);
                    compare_field("red", 32'(want.red), 32'(m_tdata[75:68]));
                    compare_field("green", 32'(want.green), 32'(m_tdata[83:76]));
                    compare_field("blue", 32'(want.blue), 32'(m_tdata[91:84]));
                    compare_field("alpha", 32'(want.alpha), 32'(m_tdata[99:92]));
                    compare_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Ends the run if neither side completes a transfer for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Queues a file; only the first cut bytes are sent when cut is not negative.
    task automatic add_file(input int id_n, input int cmap, input int itype, input int w,
                            input int h, input int depth, input bit top, input int raster_n,
                            input int cut);
        logic [7:0] bytes[$];
        logic [7:0] desc;
        in_item_t   it;
        int         n;
        bytes.push_back(8'(id_n));
        bytes.push_back(8'(cmap));
        bytes.push_back(8'(itype));
        repeat (9) bytes.push_back(8'($urandom));
        bytes.push_back(8'(w));
        bytes.push_back(8'(w >> 8));
        bytes.push_back(8'(h));
        bytes.push_back(8'(h >> 8));
        bytes.push_back(8'(depth));
        desc = 8'($urandom);
        desc[5] = top;
        bytes.push_back(desc);
        repeat (id_n) bytes.push_back(8'($urandom));
        repeat (raster_n) bytes.push_back(8'($urandom));
        n = (cut < 0 || cut > bytes.size()) ? bytes.size() : cut;
        for (int i = 0; i < n; i++) begin
            it.data_byte = bytes[i];
            it.first_byte = (i == 0);
            file_bytes_q.push_back(it);
        end
    endtask

    task automatic add_noise(input int n);
        in_item_t it;
        repeat (n) begin
            it.data_byte = 8'($urandom);
            it.first_byte = 1'b0;
            file_bytes_q.push_back(it);
        end
    endtask

    task automatic random_file();
        int              sel;
        int              id_n;
        int              cmap;
        int              itype;
        int              w;
        int              h;
        int              depth;
        int              raster_n;
        int              total;
        int              cut;
        longint unsigned full;
        sel = $urandom_range(99);
        id_n = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(5);
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        if ($urandom_range(24) == 0) w = 0;
        if ($urandom_range(24) == 0) h = 0;
        depth = $urandom_range(1) ? 32 : 24;
        cmap = 0;
        itype = 2;
        if (sel < 15) begin
            case ($urandom_range(2))
                0: cmap = $urandom_range(1, 255);
                1: begin
                    itype = $urandom_range(255);
                    if (itype == 2) itype = 10;
                end
                default: begin
                    do depth = $urandom_range(255); while (depth == 24 || depth == 32);
                end
            endcase
        end else if (sel < 22) begin
            w = $urandom_range(65535);
            h = $urandom_range(65535);
        end
        full = longint'(w) * longint'(h) * ((depth == 32) ? 4 : 3);
        raster_n = (full > 120) ? $urandom_range(40) : int'(full);
        total = 18 + id_n + raster_n;
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, total) : -1;
        add_file(id_n, cmap, itype, w, h, depth, $urandom_range(1), raster_n, cut);
        if ($urandom_range(9) == 0) add_noise($urandom_range(1, 4));
    endtask

    // Waits until every byte is sent and every result has come back, then lets the
    // pipeline settle, since the last bytes may have caused no result.
    task automatic wait_drained();
        do @(negedge aclk);
        while (file_bytes_q.size() != 0 || s_tvalid || decoded_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic start_phase(input logic [31:0] length, input int mode);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= length;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        file_len = length;
        send_idle_pct = (mode == 1) ? 60 : (mode == 3) ? 15 : 0;
        recv_stall_pct = (mode == 2) ? 60 : (mode == 3) ? 15 : 0;
    endtask

    initial begin
        int start;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero length: every header is too short.
        start_phase(32'd0, 0);
        add_file(0, 0, 2, 1, 1, 24, 1'b1, 3, 1);
        add_noise(2);
        add_file(255, 0, 2, 1, 1, 24, 1'b1, 3, 2);

        // Length exactly at the header and raster limits.
        start_phase(32'd33, 0);
        add_file(3, 0, 2, 2, 2, 24, 1'b0, 12, -1);
        add_file(15, 0, 2, 0, 5, 32, 1'b1, 0, 18);
        add_file(16, 0, 2, 1, 1, 24, 1'b1, 0, 1);
        add_file(3, 0, 2, 2, 2, 32, 1'b1, 16, 18);

        // Largest length: header errors, huge images and long ID fields.
        start_phase(32'hFFFF_FFFF, 0);
        add_file(0, 1, 2, 1, 1, 24, 1'b1, 0, 2);
        add_file(0, 0, 3, 1, 1, 24, 1'b1, 0, 3);
        add_file(0, 0, 2, 300, 7, 8, 1'b1, 0, 17);
        add_file(0, 0, 2, 65535, 65535, 32, 1'b1, 0, 18);
        add_file(2, 0, 2, 65535, 16384, 24, 1'b0, 6, -1);
        add_file(0, 0, 2, 1, 65535, 24, 1'b0, 6, -1);
        add_file(0, 0, 2, 2, 1, 32, 1'b1, 8, -1);
        add_file(0, 0, 2, 4, 4, 24, 1'b1, 0, 10);
        add_file(255, 0, 2, 3, 2, 24, 1'b0, 18, -1);
        add_file(1, 0, 2, 65535, 1, 32, 1'b0, 12, -1);

        for (int p = 0; p < 8; p++) begin
            if (p == 3)
                start_phase(32'hFFFF_FFFF, p % 4);
            else if (p == 6)
                start_phase(32'($urandom), p % 4);
            else
                start_phase(32'($urandom_range(60, 400)), p % 4);
            start = file_bytes_q.size();
            while (file_bytes_q.size() - start < 100) random_file();
        end

        wait_drained();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ tga_truecolor_stream_decoder_top.f @@
+incdir+sv
sv/tgad_pkg.sv
sv/tgad_in_stage.sv
sv/tgad_core.sv
sv/tgad_out_stage.sv
sv/tga_truecolor_stream_decoder_top.sv
sim/tga_truecolor_stream_decoder_top_test.sv
